// ----- rtl/bsc_pkg.sv -----
// Shared constants, codes and types of the bit set with population count.
package bsc_pkg;

  localparam int MAX_BITS    = 4096;
  localparam int WORD_BITS   = 8;
  localparam int WORD_COUNT  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W       = $clog2(MAX_BITS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int LIM_W       = 13;
  localparam int WADDR_W     = $clog2(WORD_COUNT);
  localparam int BSEL_W      = $clog2(WORD_BITS);
  localparam int CMD_W       = 3;
  localparam int STAT_W      = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(4096);

  // Command codes on the input port.
  localparam logic [CMD_W-1:0] CMD_SET     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLR     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TEST    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLR_ALL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_ALL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND    = 3'd5;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;

  // Operation as classified by the front end.
  typedef enum logic [2:0] {
    OP_SET,
    OP_CLR,
    OP_TEST,
    OP_CLR_ALL,
    OP_SET_ALL,
    OP_FIND,
    OP_REJECT,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_SWEEP,
    BK_FIND
  } bk_state_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] lim;
  } job_t;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic              bit_value;
    logic [IDX_W-1:0]  found_index;
    logic [CNT_W-1:0]  set_count;
    logic [IDX_W-1:0]  high_mark;
  } res_t;

  typedef struct packed {
    logic full;
    logic init;
  } fe_stat_t;

endpackage

// ----- rtl/bsc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module bsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bsc_front.sv -----
// Front end: limit register, command decode and range check, queue push.
module bsc_front import bsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_bit_index,
  input  logic              cfg_we,
  input  logic [LIM_W-1:0]  cfg_wdata,
  input  fe_stat_t          stat,
  output logic              busy,
  output logic              push,
  output job_t              job
);

  logic [LIM_W-1:0] limit_r;
  logic [CNT_W-1:0] lim_eff;
  logic             in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // A limit above the storage size acts as the storage size.
  assign lim_eff  = (limit_r > LIM_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : CNT_W'(limit_r);
  assign in_range = {1'b0, in_bit_index} < lim_eff;

  assign busy = stat.full | stat.init;
  assign push = start & ~busy;

  always_comb begin
    job.idx = in_bit_index;
    job.lim = lim_eff;
    unique case (in_command)
      CMD_SET:     job.op = in_range ? OP_SET  : OP_REJECT;
      CMD_CLR:     job.op = in_range ? OP_CLR  : OP_REJECT;
      CMD_TEST:    job.op = in_range ? OP_TEST : OP_REJECT;
      CMD_FIND:    job.op = in_range ? OP_FIND : OP_REJECT;
      CMD_CLR_ALL: job.op = OP_CLR_ALL;
      CMD_SET_ALL: job.op = OP_SET_ALL;
      default:     job.op = OP_NOP;
    endcase
  end

endmodule

// ----- rtl/bsc_queue.sv -----
// Short queue of classified jobs between the front and back ends.
module bsc_queue import bsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output job_t q_job
);

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_valid = cnt_r != '0;
  assign q_full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign q_job   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/bsc_back.sv -----
// Back end: executes jobs against the word memory and builds each result.
module bsc_back import bsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  job_t                 q_job,
  output logic                 pop,
  output logic                 init_busy,
  output logic                 ram_we,
  output logic [WADDR_W-1:0]   ram_waddr,
  output logic [WORD_BITS-1:0] ram_wdata,
  output logic                 ram_re,
  output logic [WADDR_W-1:0]   ram_raddr,
  input  logic [WORD_BITS-1:0] ram_rdata,
  output res_t                 res
);

  bk_state_t          state_r, state_nxt;
  logic [WADDR_W-1:0] addr_r, addr_nxt;
  job_t               job_r, job_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   high_r, high_nxt;
  res_t               res_r, res_nxt;

  logic [WADDR_W-1:0]   q_word;
  logic                 last_addr;
  logic                 rd_bit;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] fill_word;
  logic [WORD_BITS-1:0] part_mask;
  logic [WORD_BITS-1:0] scan_word;
  logic                 scan_hit;
  logic                 scan_last;
  logic [BSEL_W-1:0]    hit_bit;
  logic [CNT_W-1:0]     lim_m1;
  logic                 find_skip;

  assign q_word    = q_job.idx[IDX_W-1:BSEL_W];
  assign last_addr = addr_r == WADDR_W'(WORD_COUNT - 1);
  assign rd_bit    = ram_rdata[job_r.idx[BSEL_W-1:0]];
  assign bit_mask  = WORD_BITS'(1) << job_r.idx[BSEL_W-1:0];
  assign lim_m1    = job_r.lim - CNT_W'(1);
  assign find_skip = q_job.idx > high_r;
  assign init_busy = state_r == BK_INIT;
  assign res       = res_r;

  // Set-all word: full below the limit's word, partial in it, empty above.
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      part_mask[b] = BSEL_W'(b) < job_r.lim[BSEL_W-1:0];
    end
    if ({1'b0, addr_r} < job_r.lim[CNT_W-1:BSEL_W]) begin
      fill_word = '1;
    end else if ({1'b0, addr_r} == job_r.lim[CNT_W-1:BSEL_W]) begin
      fill_word = part_mask;
    end else begin
      fill_word = '0;
    end
  end

  // The search window opens at the start bit and closes at the high mark.
  assign scan_last = addr_r == high_r[IDX_W-1:BSEL_W];
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      scan_word[b] = ram_rdata[b]
        & ((addr_r != job_r.idx[IDX_W-1:BSEL_W]) || (BSEL_W'(b) >= job_r.idx[BSEL_W-1:0]))
        & (!scan_last || (BSEL_W'(b) <= high_r[BSEL_W-1:0]));
    end
    hit_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (scan_word[b]) begin
        hit_bit = BSEL_W'(b);
      end
    end
  end
  assign scan_hit = scan_word != '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_INIT: begin
        if (last_addr) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_job.op)
            OP_SET, OP_CLR, OP_TEST: state_nxt = BK_READ;
            OP_CLR_ALL, OP_SET_ALL:  state_nxt = BK_SWEEP;
            OP_FIND:                 state_nxt = find_skip ? BK_IDLE : BK_FIND;
            OP_REJECT, OP_NOP:       state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_READ: state_nxt = BK_IDLE;
      BK_SWEEP: begin
        if (last_addr) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_FIND: begin
        if (scan_hit || scan_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = addr_r;
    addr_nxt  = addr_r;
    job_nxt   = job_r;
    count_nxt = count_r;
    high_nxt  = high_r;
    res_nxt   = '0;
    unique case (state_r)
      BK_INIT: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
      end
      BK_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          job_nxt = q_job;
          unique case (q_job.op)
            OP_SET, OP_CLR, OP_TEST: begin
              ram_re    = 1'b1;
              ram_raddr = q_word;
            end
            OP_CLR_ALL, OP_SET_ALL: begin
              addr_nxt = '0;
            end
            OP_FIND: begin
              if (find_skip) begin
                res_nxt.valid  = 1'b1;
                res_nxt.status = STAT_NONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = q_word;
                addr_nxt  = q_word;
              end
            end
            OP_REJECT: begin
              res_nxt.valid  = 1'b1;
              res_nxt.status = STAT_RANGE;
            end
            OP_NOP: begin
              res_nxt.valid = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        res_nxt.valid     = 1'b1;
        res_nxt.bit_value = rd_bit;
        if (job_r.op != OP_TEST) begin
          ram_we    = 1'b1;
          ram_waddr = job_r.idx[IDX_W-1:BSEL_W];
          if (job_r.op == OP_SET) begin
            ram_wdata = ram_rdata | bit_mask;
            if (!rd_bit) begin
              count_nxt = count_r + 1'b1;
            end
          end else begin
            ram_wdata = ram_rdata & ~bit_mask;
            if (rd_bit && count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end
          end
          if (job_r.idx > high_r) begin
            high_nxt = job_r.idx;
          end
        end
      end
      BK_SWEEP: begin
        ram_we    = 1'b1;
        ram_wdata = (job_r.op == OP_SET_ALL) ? fill_word : '0;
        addr_nxt  = addr_r + 1'b1;
        if (last_addr) begin
          res_nxt.valid = 1'b1;
          if (job_r.op == OP_SET_ALL) begin
            count_nxt = job_r.lim;
            high_nxt  = (job_r.lim != '0) ? lim_m1[IDX_W-1:0] : '0;
          end else begin
            count_nxt = '0;
            high_nxt  = '0;
          end
        end
      end
      BK_FIND: begin
        if (scan_hit) begin
          res_nxt.valid       = 1'b1;
          res_nxt.found_index = {addr_r, hit_bit};
        end else if (scan_last) begin
          res_nxt.valid  = 1'b1;
          res_nxt.status = STAT_NONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_r + 1'b1;
          addr_nxt  = addr_r + 1'b1;
        end
      end
      default: begin
        addr_nxt = addr_r;
      end
    endcase
    res_nxt.set_count = count_nxt;
    res_nxt.high_mark = high_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      addr_r      <= '0;
      count_r     <= '0;
      high_r      <= '0;
      res_r.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      count_r <= count_nxt;
      high_r  <= high_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

// ----- rtl/bitmap_set_with_count.sv -----
// Top level of the bit set with population count.
//
//   channel  direction  handshake                  payload
//   in_      in         start / busy, beat when    in_command, in_bit_index
//                       start && !busy
//   out_     out        out_valid strobe, 1 cycle  out_status, out_bit_value,
//                                                  out_found_index, out_set_count,
//                                                  out_high_mark
//   cfg_     in         cfg_we, no wait            cfg_wdata (bit limit)
//
// Set and clear read the word, then write it back; test only reads it; find
// scans one word per cycle; clear-all and set-all sweep all 512 words.
// The back end reaches the word memory through one write and one read port.
// After reset a clearing pass zeroes all 512 words with busy high.
// A 2-entry queue lets the front end take beats while the back end works;
// after the clearing pass busy rises only when the queue is full. Results
// cannot be stalled.
module bitmap_set_with_count import bsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_bit_index,
  input  logic              cfg_we,
  input  logic [LIM_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic              out_bit_value,
  output logic [IDX_W-1:0]  out_found_index,
  output logic [CNT_W-1:0]  out_set_count,
  output logic [IDX_W-1:0]  out_high_mark
);

  fe_stat_t             fe_stat;
  logic                 push;
  job_t                 push_job;
  logic                 pop;
  logic                 q_valid;
  logic                 q_full;
  job_t                 q_job;
  logic                 init_busy;
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  res_t                 res;

  assign fe_stat.full = q_full;
  assign fe_stat.init = init_busy;

  bsc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_command   (in_command),
    .in_bit_index (in_bit_index),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .stat         (fe_stat),
    .busy         (busy),
    .push         (push),
    .job          (push_job)
  );

  bsc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_job    (q_job)
  );

  bsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .init_busy (init_busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res)
  );

  bsc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_words (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid       = res.valid;
  assign out_status      = res.status;
  assign out_bit_value   = res.bit_value;
  assign out_found_index = res.found_index;
  assign out_set_count   = res.set_count;
  assign out_high_mark   = res.high_mark;

endmodule

// ----- rtl/bsc_checker.sv -----
// Port-level checks on the bit set, bound to the top level.
module bsc_checker import bsc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input logic [STAT_W-1:0] out_status,
  input logic              out_bit_value,
  input logic [IDX_W-1:0]  out_found_index,
  input logic [CNT_W-1:0]  out_set_count
);

  // Reset starts the clearing pass, so no beat is taken and no result shows.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("busy low or result shown right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_RANGE ||
                   out_status == STAT_NONE))
    else $error("result with an undefined status");

  // A rejected command or a failed search reports no bit and no index.
  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> !out_bit_value && out_found_index == '0)
    else $error("failed result carries a bit value or index");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_set_count <= CNT_W'(MAX_BITS))
    else $error("set count above the storage size");

endmodule

bind bitmap_set_with_count bsc_checker u_bsc_checker (.*);
